// ===== src/rmbt_pkg.sv =====
// Package for the RGB multiband threshold unit: payload types and register codes.
`default_nettype none

package rmbt_pkg;

  // Configuration port widths.
  localparam int unsigned CfgIndexWidth = 8;
  localparam int unsigned CfgDataWidth  = 36;

  // Register indexes.
  localparam logic [CfgIndexWidth-1:0] REG_MAX_COLOR_ONLY  = 8'd0;
  localparam logic [CfgIndexWidth-1:0] REG_MIN_THRESHOLDS  = 8'd1;
  localparam logic [CfgIndexWidth-1:0] REG_MAX_THRESHOLDS  = 8'd2;
  localparam logic [CfgIndexWidth-1:0] REG_BELOW_VALUES    = 8'd3;
  localparam logic [CfgIndexWidth-1:0] REG_ABOVE_VALUES    = 8'd4;
  localparam logic [CfgIndexWidth-1:0] REG_PASS_VALUES     = 8'd5;
  localparam logic [CfgIndexWidth-1:0] REG_GREY_PASS_MODE  = 8'd6;
  localparam logic [CfgIndexWidth-1:0] REG_GREY_PASS_VALUE = 8'd7;

  // Grey pass modes; the remaining code behaves as the per-channel rule.
  localparam logic [1:0] GREY_MODE_CHANNEL  = 2'd0;
  localparam logic [1:0] GREY_MODE_CONVERT  = 2'd1;
  localparam logic [1:0] GREY_MODE_CONSTANT = 2'd2;

  // Grey weights in thousandths.
  localparam logic [9:0] WeightRed   = 10'd299;
  localparam logic [9:0] WeightGreen = 10'd587;
  localparam logic [9:0] WeightBlue  = 10'd114;

  // Weighted sum fits 18 bits (at most 255000); floor(sum / 1000) is
  // (sum * RecipMult) >> RecipShift, exact for every sum below 493447.
  localparam int unsigned SumWidth   = 18;
  localparam int unsigned RecipShift = 28;
  localparam logic [18:0] RecipMult  = 19'd268436;
  localparam int unsigned ProdWidth  = 37;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_pixel_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_pixel_t;

endpackage

`default_nettype wire

// ===== src/rgb_multiband_threshold_unit.sv =====
// Top level of the RGB multiband threshold unit: a four-stage pixel pipeline.
//
// Usage. Pixels enter on the in channel (in_valid, in_ready, in_data) and the
// filtered pixels leave on the out channel (out_valid, out_ready, out_data),
// one result for each pixel, in order. Registers are written over the cfg
// channel (cfg_valid, cfg_ready, cfg_index, cfg_data); cfg_ready is always
// high and a write to an index beyond the list is dropped. Write registers
// only while no pixel is in flight.
// An accepted pixel passes through four register stages in order (max colour,
// weighted sum, reciprocal multiply, threshold select); the last drives out_data.
// Throughput: one pixel per cycle while the receiver keeps out_ready high.
// Each stage has its own valid bit and advances whenever the stage after it
// is empty or moving, so bubbles close up while the receiver stalls; a
// stalled output holds its pixel and nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline and loads the register reset
// values: all zero, except above_values which is all ones.
`default_nettype none

module rgb_multiband_threshold_unit
  import rmbt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output      logic                     in_ready,
  input  wire in_pixel_t                in_data,
  output      logic                     out_valid,
  input  wire logic                     out_ready,
  output      out_pixel_t               out_data,
  input  wire logic                     cfg_valid,
  output      logic                     cfg_ready,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data
);

  // Configuration registers.
  logic        peak_only;
  logic [35:0] min_thresholds;
  logic [35:0] max_thresholds;
  logic [31:0] below_values;
  logic [31:0] above_values;
  logic [26:0] pass_values;
  logic [1:0]  grey_pass_mode;
  logic [7:0]  grey_pass_value;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_only       <= 1'b0;
      min_thresholds  <= '0;
      max_thresholds  <= '0;
      below_values    <= '0;
      above_values    <= '1;
      pass_values     <= '0;
      grey_pass_mode  <= GREY_MODE_CHANNEL;
      grey_pass_value <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_COLOR_ONLY:  peak_only       <= cfg_data[0];
        REG_MIN_THRESHOLDS:  min_thresholds  <= cfg_data[35:0];
        REG_MAX_THRESHOLDS:  max_thresholds  <= cfg_data[35:0];
        REG_BELOW_VALUES:    below_values    <= cfg_data[31:0];
        REG_ABOVE_VALUES:    above_values    <= cfg_data[31:0];
        REG_PASS_VALUES:     pass_values     <= cfg_data[26:0];
        REG_GREY_PASS_MODE:  grey_pass_mode  <= cfg_data[1:0];
        REG_GREY_PASS_VALUE: grey_pass_value <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and advance enables.
  logic valid1, valid2, valid3, valid4;
  logic en1, en2, en3, en4;

  assign en4      = !valid4 || out_ready;
  assign en3      = !valid3 || en4;
  assign en2      = !valid2 || en3;
  assign en1      = !valid1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
      valid4 <= 1'b0;
    end else begin
      if (en1) valid1 <= in_valid;
      if (en2) valid2 <= valid1;
      if (en3) valid3 <= valid2;
      if (en4) valid4 <= valid3;
    end
  end

  // Stage 1: max colour only mode zeroes channels below the largest.
  logic [7:0] chan1_next [3];
  logic [7:0] chan1 [3];
  logic [7:0] chan_max;

  always_comb begin
    chan1_next[0] = in_data.in_red;
    chan1_next[1] = in_data.in_green;
    chan1_next[2] = in_data.in_blue;
    chan_max = chan1_next[0];
    if (chan1_next[1] > chan_max) chan_max = chan1_next[1];
    if (chan1_next[2] > chan_max) chan_max = chan1_next[2];
    if (peak_only) begin
      for (int k = 0; k < 3; k++) begin
        if (chan1_next[k] < chan_max) chan1_next[k] = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) chan1 <= chan1_next;
  end

  // Stage 2: weighted sum of the channels in thousandths.
  logic [SumWidth-1:0] sum2_next;
  logic [SumWidth-1:0] sum2;
  logic [7:0]          chan2 [3];

  assign sum2_next = SumWidth'(WeightRed * chan1[0])
                   + SumWidth'(WeightGreen * chan1[1])
                   + SumWidth'(WeightBlue * chan1[2]);

  always_ff @(posedge clk) begin
    if (en2) begin
      sum2  <= sum2_next;
      chan2 <= chan1;
    end
  end

  // Stage 3: divide by 1000 through the reciprocal multiply.
  logic [ProdWidth-1:0] prod3;
  logic [7:0]           grey3;
  logic [7:0]           chan3 [3];

  assign prod3 = ProdWidth'(sum2) * ProdWidth'(RecipMult);

  always_ff @(posedge clk) begin
    if (en3) begin
      grey3 <= prod3[RecipShift +: 8];
      chan3 <= chan2;
    end
  end

  // Stage 4: base output, then the threshold overrides in priority order.
  logic [7:0] out4_next [3];
  logic       grey_under_min;
  logic       grey_over_max;

  assign grey_under_min = min_thresholds[35] && (grey3 < min_thresholds[34:27]);
  assign grey_over_max  = max_thresholds[35] && (grey3 > max_thresholds[34:27]);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (grey_pass_mode)
        GREY_MODE_CONVERT:  out4_next[k] = grey3;
        GREY_MODE_CONSTANT: out4_next[k] = grey_pass_value;
        default: begin
          out4_next[k] = pass_values[9*k+8] ? pass_values[9*k +: 8] : chan3[k];
        end
      endcase
      if (min_thresholds[9*k+8] && (chan3[k] < min_thresholds[9*k +: 8])) begin
        out4_next[k] = below_values[8*k +: 8];
      end
      if (grey_under_min) out4_next[k] = below_values[31:24];
      if (max_thresholds[9*k+8] && (chan3[k] > max_thresholds[9*k +: 8])) begin
        out4_next[k] = above_values[8*k +: 8];
      end
      if (grey_over_max) out4_next[k] = above_values[31:24];
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      out_data.out_red   <= out4_next[0];
      out_data.out_green <= out4_next[1];
      out_data.out_blue  <= out4_next[2];
    end
  end

  assign out_valid = valid4;

  // A full stage that cannot move must block the input.
  assert property (@(posedge clk) disable iff (rst)
    (valid1 && !en2) |-> !in_ready)
    else $error("input taken while the first stage is blocked");

  // An accepted pixel always lands in the first stage.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> valid1)
    else $error("accepted pixel missing from the first stage");

  // The quotient never exceeds eight bits.
  assert property (@(posedge clk) disable iff (rst)
    valid2 |-> (prod3[ProdWidth-1] == 1'b0))
    else $error("grey quotient overflow");

  // A stalled output stage keeps its pixel, and a full third stage waits behind it.
  assert property (@(posedge clk) disable iff (rst)
    (valid4 && !out_ready && valid3) |=> valid4 && valid3)
    else $error("pixel dropped during a stall");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the RGB multiband threshold unit, with its own pixel predictor.
`timescale 1ns / 100ps

module tb_top
  import rmbt_pkg::*;
;

  // Grey weights in thousandths.
  localparam int unsigned W_RED        = 299;
  localparam int unsigned W_GREEN      = 587;
  localparam int unsigned W_BLUE       = 114;
  localparam int unsigned GREY_DIVISOR = 1000;

  // Indexes that decode to no register.
  localparam logic [CfgIndexWidth-1:0] REG_UNUSED_FIRST = 8'd8;
  localparam logic [CfgIndexWidth-1:0] REG_UNUSED_LAST  = 8'hFF;

  localparam int unsigned PIPE_DEPTH       = 4;
  localparam int unsigned DRAIN_MARGIN     = 2 * PIPE_DEPTH;
  localparam int unsigned WATCHDOG_LIMIT   = 2000;
  localparam int unsigned RANDOM_SEGMENTS  = 16;
  localparam int unsigned SEGMENT_PIXELS   = 100;

  typedef struct {
    logic [CfgIndexWidth-1:0] index;
    logic [CfgDataWidth-1:0]  value;
  } reg_write_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  in_pixel_t                in_data   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_pixel_t               out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data  = '0;

  // Shadow copy of the register file, updated on each accepted write.
  logic        shadow_max_only   = 1'b0;
  logic [35:0] shadow_min        = '0;
  logic [35:0] shadow_max        = '0;
  logic [31:0] shadow_below      = '0;
  logic [31:0] shadow_above      = 32'hFFFF_FFFF;
  logic [26:0] shadow_pass       = '0;
  logic [1:0]  shadow_grey_mode  = GREY_MODE_CHANNEL;
  logic [7:0]  shadow_grey_value = '0;

  in_pixel_t   pending_pixels[$];
  out_pixel_t  expected_pixels[$];
  reg_write_t  reg_writes[$];

  int unsigned send_idle_pct = 20;
  int unsigned stall_pct     = 56;
  int unsigned fault_count   = 0;
  int unsigned quiet_cycles  = 0;

  rgb_multiband_threshold_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Filtered pixel for one input pixel under the shadow register settings.
  function automatic out_pixel_t filter_pixel(input in_pixel_t px);
    logic [7:0]  chan [3];
    logic [7:0]  res [3];
    logic [7:0]  peak;
    logic [7:0]  grey;
    int unsigned weighted;
    out_pixel_t  q;
    chan[0] = px.in_red;
    chan[1] = px.in_green;
    chan[2] = px.in_blue;
    // Max colour mode clears every channel below the brightest; ties survive.
    if (shadow_max_only) begin
      peak = chan[0];
      for (int k = 1; k < 3; k++) if (chan[k] > peak) peak = chan[k];
      for (int k = 0; k < 3; k++) if (chan[k] < peak) chan[k] = 8'd0;
    end
    weighted = W_RED * chan[0] + W_GREEN * chan[1] + W_BLUE * chan[2];
    grey = 8'(weighted / GREY_DIVISOR);
    // Base output before any threshold.
    for (int k = 0; k < 3; k++) begin
      case (shadow_grey_mode)
        GREY_MODE_CONVERT:  res[k] = grey;
        GREY_MODE_CONSTANT: res[k] = shadow_grey_value;
        default:            res[k] = shadow_pass[9*k+8] ? shadow_pass[9*k +: 8] : chan[k];
      endcase
    end
    // Below-minimum stages; the grey field sits in bits 35..27.
    for (int k = 0; k < 3; k++)
      if (shadow_min[9*k+8] && chan[k] < shadow_min[9*k +: 8]) res[k] = shadow_below[8*k +: 8];
    if (shadow_min[35] && grey < shadow_min[34:27])
      for (int k = 0; k < 3; k++) res[k] = shadow_below[31:24];
    // Above-maximum stages override everything before them.
    for (int k = 0; k < 3; k++)
      if (shadow_max[9*k+8] && chan[k] > shadow_max[9*k +: 8]) res[k] = shadow_above[8*k +: 8];
    if (shadow_max[35] && grey > shadow_max[34:27])
      for (int k = 0; k < 3; k++) res[k] = shadow_above[31:24];
    q.out_red   = res[0];
    q.out_green = res[1];
    q.out_blue  = res[2];
    return q;
  endfunction

  // Mirror of a register write; bits above a register's width are dropped.
  task automatic apply_reg(input reg_write_t w);
    case (w.index)
      REG_MAX_COLOR_ONLY:  shadow_max_only   = w.value[0];
      REG_MIN_THRESHOLDS:  shadow_min        = w.value[35:0];
      REG_MAX_THRESHOLDS:  shadow_max        = w.value[35:0];
      REG_BELOW_VALUES:    shadow_below      = w.value[31:0];
      REG_ABOVE_VALUES:    shadow_above      = w.value[31:0];
      REG_PASS_VALUES:     shadow_pass       = w.value[26:0];
      REG_GREY_PASS_MODE:  shadow_grey_mode  = w.value[1:0];
      REG_GREY_PASS_VALUE: shadow_grey_value = w.value[7:0];
      default: ;
    endcase
  endtask

  task automatic queue_reg(input logic [CfgIndexWidth-1:0] index,
                           input logic [CfgDataWidth-1:0] value);
    reg_write_t w;
    w.index = index;
    w.value = value;
    reg_writes.push_back(w);
  endtask

  task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pending_pixels.push_back({r, g, b});
  endtask

  // Random pixel, often with tied channels or channels sitting on a threshold.
  task automatic queue_random_pixel();
    in_pixel_t px;
    px = 24'($urandom);
    case ($urandom_range(0, 7))
      0: px.in_green = px.in_red;
      1: px.in_blue = px.in_green;
      2: begin
        px.in_green = px.in_red;
        px.in_blue  = px.in_red;
      end
      3: begin
        px.in_red   = shadow_min[7:0];
        px.in_green = shadow_max[16:9];
      end
      4: begin
        px.in_blue = shadow_min[25:18];
        px.in_red  = shadow_max[7:0];
      end
      default: ;
    endcase
    pending_pixels.push_back(px);
  endtask

  // Register value for a random segment: all zeros, all ones, or random content.
  function automatic logic [CfgDataWidth-1:0] register_value(input int seg,
                                                             input bit field_layout);
    logic [CfgDataWidth-1:0] v;
    v[35:32] = 4'($urandom_range(0, 15));
    v[31:0]  = $urandom;
    if (seg == 0) v = '0;
    else if (seg == 1) v = '1;
    else if (field_layout)
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(0, 3))
          0: v[9*k +: 8] = 8'h00;
          1: v[9*k +: 8] = 8'hFF;
          default: ;
        endcase
      end
    return v;
  endfunction

  // Waits until every pixel has been sent and every result has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (DRAIN_MARGIN) @(posedge clk);
  endtask

  // Sends the queued register writes once the pipeline is empty.
  task automatic program_registers();
    reg_write_t w;
    wait_drained();
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.index;
      cfg_data  <= w.value;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      apply_reg(w);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic check_channel(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      fault_count++;
      $display("%0t: %s expected %02h, got %02h", $time, name, want, got);
    end
  endtask

  // Driver: predicts each pixel as its transfer completes, then offers the next.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_pixels.push_back(filter_pixel(in_data));
      if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_pixels.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each output transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          fault_count++;
          $display("%0t: expected no pixel, got %06h", $time, out_data);
        end else begin
          check_channel("out_red", expected_pixels[0].out_red, out_data.out_red);
          check_channel("out_green", expected_pixels[0].out_green, out_data.out_green);
          check_channel("out_blue", expected_pixels[0].out_blue, out_data.out_blue);
          void'(expected_pixels.pop_front());
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("rgb_multiband_threshold_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Register reset values: pixels pass through untouched.
    queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);
    queue_pixel(8'h01, 8'h80, 8'hFE);

    // Max colour mode with grey conversion, including tied channels.
    queue_reg(REG_MAX_COLOR_ONLY, 36'h1);
    queue_reg(REG_GREY_PASS_MODE, CfgDataWidth'(GREY_MODE_CONVERT));
    program_registers();
    queue_pixel(8'hC8, 8'hC8, 8'h0A);
    queue_pixel(8'h0A, 8'h14, 8'h1E);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);
    queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'h4D, 8'h96, 8'h1D);

    // Grey constant under every threshold, with values sitting on the limits.
    queue_reg(REG_MAX_COLOR_ONLY, 36'h0);
    queue_reg(REG_GREY_PASS_MODE, CfgDataWidth'(GREY_MODE_CONSTANT));
    queue_reg(REG_GREY_PASS_VALUE, 36'hA5);
    queue_reg(REG_MIN_THRESHOLDS, {4{9'h140}});
    queue_reg(REG_BELOW_VALUES, 36'h4433_2211);
    queue_reg(REG_MAX_THRESHOLDS, {4{9'h1C0}});
    queue_reg(REG_ABOVE_VALUES, 36'h8877_6655);
    program_registers();
    queue_pixel(8'h40, 8'h40, 8'h40);
    queue_pixel(8'hC0, 8'hC0, 8'hC0);
    queue_pixel(8'h3F, 8'h80, 8'hC1);
    queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);

    // Unused grey mode code, oversized data and writes to unused indexes.
    queue_reg(REG_GREY_PASS_MODE, 36'hF_FFFF_FFF3);
    queue_reg(REG_PASS_VALUES, 36'hF_F800_0000 | {9'h156, 9'h134, 9'h112});
    queue_reg(REG_MIN_THRESHOLDS, 36'h0);
    queue_reg(REG_MAX_THRESHOLDS, 36'h0);
    queue_reg(REG_UNUSED_FIRST, '1);
    queue_reg(REG_UNUSED_LAST, '1);
    program_registers();
    queue_pixel(8'h00, 8'hFF, 8'h7F);
    queue_pixel(8'hAA, 8'h55, 8'h00);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);

    // Per-channel rule with only green replaced; bit 0 clear turns max colour off.
    queue_reg(REG_GREY_PASS_MODE, CfgDataWidth'(GREY_MODE_CHANNEL));
    queue_reg(REG_PASS_VALUES, CfgDataWidth'({9'h000, 9'h1EE, 9'h0AB}));
    queue_reg(REG_GREY_PASS_VALUE, 36'h0);
    queue_reg(REG_MAX_COLOR_ONLY, 36'hF_FFFF_FFFE);
    program_registers();
    queue_pixel(8'h12, 8'h34, 8'h56);
    queue_pixel(8'hFF, 8'h00, 8'h80);

    // Random segments, each under fresh settings; the first two are the extremes.
    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      queue_reg(REG_MAX_COLOR_ONLY, register_value(seg, 1'b0));
      queue_reg(REG_MIN_THRESHOLDS, register_value(seg, 1'b1));
      queue_reg(REG_MAX_THRESHOLDS, register_value(seg, 1'b1));
      queue_reg(REG_BELOW_VALUES, register_value(seg, 1'b0));
      queue_reg(REG_ABOVE_VALUES, register_value(seg, 1'b0));
      queue_reg(REG_PASS_VALUES, register_value(seg, 1'b1));
      queue_reg(REG_GREY_PASS_MODE, register_value(seg, 1'b0));
      queue_reg(REG_GREY_PASS_VALUE, register_value(seg, 1'b0));
      if ($urandom_range(0, 3) == 0)
        queue_reg(CfgIndexWidth'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                  register_value(seg, 1'b0));
      program_registers();
      // Sender idles lightly at first, then the receiver, then neither.
      if (seg < 5) begin
        send_idle_pct = 20;
        stall_pct     = 56;
      end else if (seg < 11) begin
        send_idle_pct = 56;
        stall_pct     = 20;
      end else begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      repeat (SEGMENT_PIXELS) queue_random_pixel();
    end

    wait_drained();
    if (fault_count == 0) begin
      $display("rgb_multiband_threshold_unit: match");
    end else begin
      $display("rgb_multiband_threshold_unit: mismatch");
    end
    $finish;
  end

endmodule
